// ===== rtl/core/gtbs_pkg.sv =====
// Glyph table search package: field widths, register indexes and item codes.
// No dependencies; used by the interfaces, the levels and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gtbs_pkg;

	localparam int unsigned CP_W     = 21;
	localparam int unsigned IDX_W    = 12;
	localparam int unsigned WIDTH_W  = 8;
	localparam int unsigned OFFSET_W = 32;
	localparam int unsigned STRIDE_W = 6;
	localparam int unsigned COUNT_W  = 13;
	localparam int unsigned BYTE_W   = 8;

	// configuration port
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_TOTAL     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERTICAL_OFFSET = 2'd2;

	// item modes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// row stride is ceil(width / 8)
	localparam logic [WIDTH_W:0] STRIDE_ROUND = 9'd7;
	localparam int unsigned      STRIDE_SHIFT = 3;

endpackage

`default_nettype wire

// ===== rtl/core/gtbs_in_if.sv =====
// Request channel of the glyph table search: load and lookup items.
// Depends on gtbs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gtbs_in_if;

	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [gtbs_pkg::IDX_W-1:0]        entry_index;
	logic [gtbs_pkg::CP_W-1:0]         codepoint;
	logic [gtbs_pkg::WIDTH_W-1:0]      glyph_width;
	logic [gtbs_pkg::OFFSET_W-1:0]     glyph_offset;

	modport source (
		output valid, mode, entry_index, codepoint, glyph_width, glyph_offset,
		input  ready
	);

	modport sink (
		input  valid, mode, entry_index, codepoint, glyph_width, glyph_offset,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/core/gtbs_out_if.sv =====
// Result channel of the glyph table search: one result item per request item.
// Depends on gtbs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface gtbs_out_if;

	logic                                valid;
	logic                                ready;
	logic                                found;
	logic [gtbs_pkg::IDX_W-1:0]          match_index;
	logic [gtbs_pkg::WIDTH_W-1:0]        width_out;
	logic [gtbs_pkg::STRIDE_W-1:0]       row_stride;
	logic [gtbs_pkg::OFFSET_W-1:0]       bitmap_offset;
	logic [gtbs_pkg::BYTE_W-1:0]         height_out;
	logic signed [gtbs_pkg::BYTE_W-1:0]  yoff_out;

	modport source (
		output valid, found, match_index, width_out, row_stride, bitmap_offset,
		       height_out, yoff_out,
		input  ready
	);

	modport sink (
		input  valid, found, match_index, width_out, row_stride, bitmap_offset,
		       height_out, yoff_out,
		output ready
	);

endinterface

`default_nettype wire

// ===== rtl/core/gtbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gtbs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gtbs_level.sv =====
// One probe level of the pipelined binary search: a private copy of the
// codepoint table, the probe register and the window update.
// Depends on gtbs_pkg and gtbs_ram; the probe struct type comes from the top.
`timescale 1ns / 1ps
`default_nettype none

module gtbs_level #(
	parameter int unsigned DEPTH   = 4096,
	parameter type         probe_t = logic
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire logic   in_valid,
	input  wire probe_t in_probe,
	output logic        out_valid,
	output probe_t      out_probe
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W:0]              mid_sum;
	logic [IDX_W-1:0]            mid;
	probe_t                      enter;
	logic                        valid_s1;
	probe_t                      probe_s1;
	logic [gtbs_pkg::CP_W-1:0]   rd_cp;
	logic                        wr_en;

	// probe point of the window [lo, lim)
	assign mid_sum = (CNT_W+1)'(in_probe.lo) + (CNT_W+1)'(in_probe.lim) - (CNT_W+1)'(1);
	assign mid     = IDX_W'(mid_sum >> 1);

	always_comb begin
		enter     = in_probe;
		enter.mid = mid;
	end

	// a load writes this copy when it passes, so reads and writes keep item order
	assign wr_en = en && in_valid && in_probe.load && in_probe.wr_en;

	gtbs_ram #(
		.WIDTH (gtbs_pkg::CP_W),
		.DEPTH (DEPTH)
	) u_cp_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (in_probe.idx),
		.wdata (in_probe.cp),
		.re    (en),
		.raddr (mid),
		.rdata (rd_cp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			probe_s1 <= enter;
		end
	end

	always_comb begin
		out_probe = probe_s1;
		if (!probe_s1.done) begin
			if (probe_s1.cp < rd_cp) begin
				out_probe.lim = CNT_W'(probe_s1.mid);
			end else if (probe_s1.cp > rd_cp) begin
				out_probe.lo = CNT_W'(probe_s1.mid) + CNT_W'(1);
			end else begin
				out_probe.hit   = 1'b1;
				out_probe.match = probe_s1.mid;
				out_probe.done  = 1'b1;
			end
			// empty window: miss
			if (!out_probe.done && (out_probe.lo >= out_probe.lim)) begin
				out_probe.done = 1'b1;
			end
		end
	end

	assign out_valid = valid_s1;

endmodule

`default_nettype wire

// ===== rtl/core/glyph_table_binary_search.sv =====
// Glyph table binary search: one probe level per stage, each with its own copy of
// the codepoint table, then one stage for the width/offset table read and finally
// the result register.
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Reset clears valid bits and configuration; tables are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module glyph_table_binary_search #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [gtbs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [gtbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	gtbs_in_if.sink                                req,
	gtbs_out_if.source                             rsp
);

	localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned LEVELS = CNT_W;
	localparam int unsigned DATA_W = gtbs_pkg::WIDTH_W + gtbs_pkg::OFFSET_W;

	typedef struct packed {
		logic                              load;
		logic                              wr_en;
		logic [IDX_W-1:0]                  idx;
		logic [gtbs_pkg::CP_W-1:0]         cp;
		logic [gtbs_pkg::WIDTH_W-1:0]      width;
		logic [gtbs_pkg::OFFSET_W-1:0]     offset;
		logic                              hit;
		logic                              done;
		logic [IDX_W-1:0]                  match;
		logic [CNT_W-1:0]                  lo;
		logic [CNT_W-1:0]                  lim;
		logic [IDX_W-1:0]                  mid;
	} probe_t;

	logic [gtbs_pkg::COUNT_W-1:0]  entry_total_q;
	logic [gtbs_pkg::BYTE_W-1:0]   cell_height_q;
	logic [gtbs_pkg::BYTE_W-1:0]   vertical_offset_q;

	logic                          adv;
	logic [CNT_W-1:0]              span;
	logic                          lvl_valid [LEVELS+1];
	probe_t                        lvl_probe [LEVELS+1];

	logic                          data_we;
	logic [DATA_W-1:0]             data_rd;
	logic                          f_valid_s;
	probe_t                        f_probe_s;
	logic [gtbs_pkg::WIDTH_W-1:0]  f_width;

	logic                          out_valid_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_total_q     <= '0;
			cell_height_q     <= '0;
			vertical_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				gtbs_pkg::CFG_ENTRY_TOTAL: begin
					entry_total_q <= cfg_data;
				end
				gtbs_pkg::CFG_CELL_HEIGHT: begin
					cell_height_q <= cfg_data[gtbs_pkg::BYTE_W-1:0];
				end
				gtbs_pkg::CFG_VERTICAL_OFFSET: begin
					vertical_offset_q <= cfg_data[gtbs_pkg::BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// the whole pipeline moves while the result register is free or being taken
	assign adv       = !out_valid_q || rsp.ready;
	assign req.ready = adv;

	// search window covers at most the table
	assign span = (32'(entry_total_q) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
	                                                      : CNT_W'(entry_total_q);

	always_comb begin
		lvl_valid[0]        = req.valid;
		lvl_probe[0].load   = (req.mode == gtbs_pkg::MODE_LOAD);
		lvl_probe[0].wr_en  = 32'(req.entry_index) < 32'(TABLE_DEPTH);
		lvl_probe[0].idx    = IDX_W'(req.entry_index);
		lvl_probe[0].cp     = req.codepoint;
		lvl_probe[0].width  = req.glyph_width;
		lvl_probe[0].offset = req.glyph_offset;
		lvl_probe[0].hit    = 1'b0;
		lvl_probe[0].done   = (req.mode == gtbs_pkg::MODE_LOAD) || (span == '0);
		lvl_probe[0].match  = '0;
		lvl_probe[0].lo     = '0;
		lvl_probe[0].lim    = span;
		lvl_probe[0].mid    = '0;
	end

	for (genvar k = 0; k < LEVELS; k++) begin : g_level
		gtbs_level #(
			.DEPTH   (TABLE_DEPTH),
			.probe_t (probe_t)
		) u_level (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (lvl_valid[k]),
			.in_probe  (lvl_probe[k]),
			.out_valid (lvl_valid[k+1]),
			.out_probe (lvl_probe[k+1])
		);
	end

	// width and offset of the matching entry
	assign data_we = adv && lvl_valid[LEVELS] && lvl_probe[LEVELS].load
	                 && lvl_probe[LEVELS].wr_en;

	gtbs_ram #(
		.WIDTH (DATA_W),
		.DEPTH (TABLE_DEPTH)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (lvl_probe[LEVELS].idx),
		.wdata ({lvl_probe[LEVELS].width, lvl_probe[LEVELS].offset}),
		.re    (adv),
		.raddr (lvl_probe[LEVELS].match),
		.rdata (data_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_valid_s <= 1'b0;
		end else if (adv) begin
			f_valid_s <= lvl_valid[LEVELS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_probe_s <= lvl_probe[LEVELS];
		end
	end

	assign f_width = data_rd[DATA_W-1 -: gtbs_pkg::WIDTH_W];

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= f_valid_s;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (f_probe_s.hit) begin
				rsp.found         <= 1'b1;
				rsp.match_index   <= gtbs_pkg::IDX_W'(f_probe_s.match);
				rsp.width_out     <= f_width;
				rsp.row_stride    <= gtbs_pkg::STRIDE_W'(((gtbs_pkg::WIDTH_W+1)'(f_width)
				                     + gtbs_pkg::STRIDE_ROUND) >> gtbs_pkg::STRIDE_SHIFT);
				rsp.bitmap_offset <= data_rd[gtbs_pkg::OFFSET_W-1:0];
				rsp.height_out    <= cell_height_q;
				rsp.yoff_out      <= vertical_offset_q;
			end else begin
				rsp.found         <= 1'b0;
				rsp.match_index   <= '0;
				rsp.width_out     <= '0;
				rsp.row_stride    <= '0;
				rsp.bitmap_offset <= '0;
				rsp.height_out    <= '0;
				rsp.yoff_out      <= '0;
			end
		end
	end

	assign rsp.valid = out_valid_q;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> lvl_valid[1])
		else $error("accepted item did not enter the first probe level");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(lvl_valid[LEVELS]) && $stable(f_valid_s) && $stable(out_valid_q))
		else $error("pipeline moved during a stall");

	a_hit_is_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_valid[LEVELS] && lvl_probe[LEVELS].hit |-> !lvl_probe[LEVELS].load)
		else $error("load item reported a hit");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> (rsp.match_index == '0) && (rsp.width_out == '0)
		&& (rsp.row_stride == '0) && (rsp.bitmap_offset == '0))
		else $error("miss result carries nonzero fields");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for glyph_table_binary_search: table loads, lookups and register
// writes, with a scoreboard that predicts every reply. Depends on gtbs_pkg and the
// gtbs_in_if / gtbs_out_if channel interfaces.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CP_W       = gtbs_pkg::CP_W;
	localparam int unsigned IDX_W      = gtbs_pkg::IDX_W;
	localparam int unsigned WIDTH_W    = gtbs_pkg::WIDTH_W;
	localparam int unsigned OFFSET_W   = gtbs_pkg::OFFSET_W;
	localparam int unsigned STRIDE_W   = gtbs_pkg::STRIDE_W;
	localparam int unsigned COUNT_W    = gtbs_pkg::COUNT_W;
	localparam int unsigned BYTE_W     = gtbs_pkg::BYTE_W;
	localparam int unsigned CFG_IDX_W  = gtbs_pkg::CFG_IDX_W;
	localparam int unsigned CFG_DATA_W = gtbs_pkg::CFG_DATA_W;

	localparam int DEPTH = 4096;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [CP_W-1:0] CP_MAX = 21'h1FFFFF;

	typedef struct packed {
		logic                mode;
		logic [IDX_W-1:0]    entry_index;
		logic [CP_W-1:0]     codepoint;
		logic [WIDTH_W-1:0]  glyph_width;
		logic [OFFSET_W-1:0] glyph_offset;
	} glyph_req_t;

	typedef struct packed {
		logic                found;
		logic [IDX_W-1:0]    match_index;
		logic [WIDTH_W-1:0]  width_out;
		logic [STRIDE_W-1:0] row_stride;
		logic [OFFSET_W-1:0] bitmap_offset;
		logic [BYTE_W-1:0]   height_out;
		logic [BYTE_W-1:0]   yoff_out;
	} glyph_reply_t;

	// Mirror of the glyph directory: table contents, registers and replies still due.
	class glyph_directory;
		bit [CP_W-1:0]     cp_tab [DEPTH];
		bit [WIDTH_W-1:0]  width_tab [DEPTH];
		bit [OFFSET_W-1:0] offset_tab [DEPTH];
		bit                loaded [DEPTH];
		bit [COUNT_W-1:0]  entry_total;
		bit [BYTE_W-1:0]   cell_height;
		bit [BYTE_W-1:0]   vertical_offset;
		glyph_reply_t      replies_due [$];
		int                mismatches;

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				gtbs_pkg::CFG_ENTRY_TOTAL:     entry_total = data;
				gtbs_pkg::CFG_CELL_HEIGHT:     cell_height = data[BYTE_W-1:0];
				gtbs_pkg::CFG_VERTICAL_OFFSET: vertical_offset = data[BYTE_W-1:0];
				default: ;
			endcase
		endfunction

		// Probe sequence of the search; -1 on a miss.
		function int search_index(logic [CP_W-1:0] cp);
			int lo, lim, mid;
			lo = 0;
			lim = (entry_total > DEPTH) ? DEPTH : int'(entry_total);
			while (lo < lim) begin
				mid = (lo + lim - 1) >> 1;
				if (cp < cp_tab[mid])
					lim = mid;
				else if (cp > cp_tab[mid])
					lo = mid + 1;
				else
					return mid;
			end
			return -1;
		endfunction

		function void note_request(glyph_req_t it);
			glyph_reply_t r;
			int hit;
			r = '0;
			if (it.mode == gtbs_pkg::MODE_LOAD) begin
				cp_tab[it.entry_index] = it.codepoint;
				width_tab[it.entry_index] = it.glyph_width;
				offset_tab[it.entry_index] = it.glyph_offset;
				loaded[it.entry_index] = 1'b1;
			end else begin
				hit = search_index(it.codepoint);
				if (hit >= 0) begin
					r.found = 1'b1;
					r.match_index = hit[IDX_W-1:0];
					r.width_out = width_tab[hit];
					r.row_stride = STRIDE_W'(({1'b0, width_tab[hit]}
						+ gtbs_pkg::STRIDE_ROUND) >> gtbs_pkg::STRIDE_SHIFT);
					r.bitmap_offset = offset_tab[hit];
					r.height_out = cell_height;
					r.yoff_out = vertical_offset;
				end
			end
			replies_due.push_back(r);
		endfunction

		function void check_reply(glyph_reply_t got);
			glyph_reply_t want;
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply with nothing due at %0t: found=%0b idx=%0d", $realtime,
						got.found, got.match_index);
				return;
			end
			want = replies_due.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at %0t", $realtime);
					$display("  want found=%0b idx=%0d w=%0d stride=%0d off=%h h=%0d yoff=%0d",
						want.found, want.match_index, want.width_out, want.row_stride,
						want.bitmap_offset, want.height_out, $signed(want.yoff_out));
					$display("  got  found=%0b idx=%0d w=%0d stride=%0d off=%h h=%0d yoff=%0d",
						got.found, got.match_index, got.width_out, got.row_stride,
						got.bitmap_offset, got.height_out, $signed(got.yoff_out));
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	gtbs_in_if  req_if ();
	gtbs_out_if rsp_if ();

	glyph_table_binary_search #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.req(req_if),
		.rsp(rsp_if)
	);

	glyph_directory sb;
	bit [CP_W-1:0]  plan_cp [DEPTH];
	int             items_sent = 0;
	int             stall_left = 0;
	bit             tx_calm = 1'b0;
	bit             rx_calm = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("testbench: errors");
		$finish;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic glyph_req_t load_item(int idx, logic [CP_W-1:0] cp,
		logic [WIDTH_W-1:0] w, logic [OFFSET_W-1:0] off);
		glyph_req_t it;
		it.mode = gtbs_pkg::MODE_LOAD;
		it.entry_index = idx[IDX_W-1:0];
		it.codepoint = cp;
		it.glyph_width = w;
		it.glyph_offset = off;
		return it;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
				sb.check_reply(glyph_reply_t'{rsp_if.found, rsp_if.match_index,
					rsp_if.width_out, rsp_if.row_stride, rsp_if.bitmap_offset,
					rsp_if.height_out, rsp_if.yoff_out});
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				rsp_if.ready <= 1'b0;
			end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
				stall_left <= gap_len();
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Call right after a rising edge; returns right after the accepting edge, or after the gap that follows it.
	task automatic push(input glyph_req_t it);
		int gap;
		req_if.valid <= 1'b1;
		req_if.mode <= it.mode;
		req_if.entry_index <= it.entry_index;
		req_if.codepoint <= it.codepoint;
		req_if.glyph_width <= it.glyph_width;
		req_if.glyph_offset <= it.glyph_offset;
		@(posedge clk);
		while (req_if.ready !== 1'b1)
			@(posedge clk);
		sb.note_request(it);
		items_sent++;
		gap = tx_calm ? 0 : gap_len();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Load every entry on the probe path that was never written, then search.
	task automatic lookup(input logic [CP_W-1:0] cp);
		glyph_req_t it;
		int lo, lim, mid;
		lo = 0;
		lim = (sb.entry_total > DEPTH) ? DEPTH : int'(sb.entry_total);
		while (lo < lim) begin
			mid = (lo + lim - 1) >> 1;
			if (!sb.loaded[mid])
				push(load_item(mid, plan_cp[mid], WIDTH_W'($urandom_range(0, 255)),
					$urandom));
			if (cp < sb.cp_tab[mid])
				lim = mid;
			else if (cp > sb.cp_tab[mid])
				lo = mid + 1;
			else
				break;
		end
		it.mode = gtbs_pkg::MODE_LOOKUP;
		it.entry_index = IDX_W'($urandom);
		it.codepoint = cp;
		it.glyph_width = WIDTH_W'($urandom);
		it.glyph_offset = $urandom;
		push(it);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// Hold requests until every reply is in, then rewrite all registers.
	task automatic configure(input int count, input int height, input int voff);
		logic [CFG_DATA_W-1:0] junk;
		req_if.valid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		junk = CFG_DATA_W'($urandom);
		put_reg(gtbs_pkg::CFG_ENTRY_TOTAL, count[CFG_DATA_W-1:0]);
		put_reg(gtbs_pkg::CFG_CELL_HEIGHT, {junk[CFG_DATA_W-1:BYTE_W], height[BYTE_W-1:0]});
		put_reg(gtbs_pkg::CFG_VERTICAL_OFFSET,
			{junk[CFG_DATA_W-1:BYTE_W], voff[BYTE_W-1:0]});
		if ($urandom_range(0, 3) == 0)
			put_reg(CFG_UNUSED, junk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int phase, n, len, k, r, i;
		logic [CP_W-1:0] c;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.mode = gtbs_pkg::MODE_LOAD;
		req_if.entry_index = '0;
		req_if.codepoint = '0;
		req_if.glyph_width = '0;
		req_if.glyph_offset = '0;
		rsp_if.ready = 1'b0;
		sb = new();

		// Strictly ascending layout spanning the whole 21-bit codepoint range.
		for (i = 0; i < DEPTH; i++)
			plan_cp[i] = CP_W'((i << 9) | $urandom_range(0, 511));
		plan_cp[0] = '0;
		plan_cp[DEPTH-1] = CP_MAX;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// font inactive after reset
		lookup('0);
		lookup(CP_MAX);

		// widths at the row stride corners, offsets at both extremes
		push(load_item(0, plan_cp[0], 8'd0, 32'h0));
		push(load_item(1, plan_cp[1], 8'd1, 32'hFFFF_FFFF));
		push(load_item(2, plan_cp[2], 8'd8, $urandom));
		push(load_item(3, plan_cp[3], 8'd9, $urandom));
		push(load_item(4, plan_cp[4], 8'd255, $urandom));
		push(load_item(DEPTH - 1, plan_cp[DEPTH-1], 8'd255, 32'hFFFF_FFFF));
		configure(5, 255, -128);
		for (i = 0; i < 5; i++)
			lookup(plan_cp[i]);
		lookup(plan_cp[2] + 1'b1);
		lookup(CP_MAX);

		// break the order, search through it, then put it back
		push(load_item(2, CP_MAX, 8'd8, $urandom));
		lookup(plan_cp[3]);
		lookup(CP_MAX);
		push(load_item(2, plan_cp[2], 8'd8, $urandom));

		phase = 0;
		while (items_sent < 1900) begin
			case (phase)
				0: configure(DEPTH, 0, 127);
				1: configure(0, 255, -128);
				2: configure(1, 0, -1);
				3: configure(8191, 255, 0);
				4: configure(2, $urandom_range(0, 255), -128);
				5: configure(255, 255, 127);
				default: begin
					r = $urandom_range(0, 9);
					if (r == 0)
						n = DEPTH;
					else if (r == 1)
						n = $urandom_range(DEPTH + 1, 8191);
					else if (r == 2)
						n = $urandom_range(0, 2);
					else if (r < 5)
						n = $urandom_range(3, 40);
					else
						n = $urandom_range(41, 400);
					configure(n, $urandom_range(0, 255), $urandom_range(0, 255));
				end
			endcase
			phase++;
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			n = (sb.entry_total > DEPTH) ? DEPTH : int'(sb.entry_total);
			len = (n == DEPTH) ? 50 : $urandom_range(60, 160);
			for (k = 0; k < len && items_sent < 1900; k++) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					// hit on a table entry, or just beside one
					if (n == 0) begin
						lookup(CP_W'($urandom));
					end else begin
						i = $urandom_range(0, n - 1);
						c = sb.loaded[i] ? sb.cp_tab[i] : plan_cp[i];
						case ($urandom_range(0, 3))
							0: c = c + 1'b1;
							1: c = c - 1'b1;
							default: ;
						endcase
						lookup(c);
					end
				end else if (r < 80) begin
					// rewrite an entry in place with fresh width and offset
					i = (n == 0) ? $urandom_range(0, DEPTH - 1) : $urandom_range(0, n - 1);
					push(load_item(i, plan_cp[i], WIDTH_W'($urandom_range(0, 255)),
						$urandom));
				end else if (r < 88) begin
					push(load_item($urandom_range(0, DEPTH - 1), CP_W'($urandom),
						WIDTH_W'($urandom_range(0, 255)), $urandom));
				end else begin
					lookup(CP_W'($urandom));
				end
			end
		end

		req_if.valid <= 1'b0;
		while (sb.replies_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.replies_due.size() == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
